[src/fccm_pkg.sv]
// Shared types and constants of the cluster chain manager.
// Used by the channel interfaces and by the top level; no dependencies.
package fccm_pkg;

	localparam int FUNC_W  = 3;
	localparam int SIZE_W  = 32;
	localparam int CLUS_W  = 16;
	localparam int COUNT_W = 11;
	localparam int CB_W    = 17;
	localparam int SE_W    = 11;

	localparam logic [CLUS_W-1:0] END_MARK   = 16'hFFFF;
	localparam logic [CLUS_W-1:0] FREE_MARK  = 16'h0000;
	localparam logic [CLUS_W-1:0] FIRST_DATA = 16'd2;

	localparam logic [CB_W-1:0] CB_RESET = 17'd2048;
	localparam logic [SE_W-1:0] SE_RESET = 11'd1000;

	// function codes of a command
	localparam logic [FUNC_W-1:0] FN_ALLOC  = 3'd0;
	localparam logic [FUNC_W-1:0] FN_FREE   = 3'd1;
	localparam logic [FUNC_W-1:0] FN_EXTEND = 3'd2;
	localparam logic [FUNC_W-1:0] FN_READ   = 3'd3;
	localparam logic [FUNC_W-1:0] FN_WRITE  = 3'd4;

	// configuration register indexes
	localparam logic CFG_CLUSTER_BYTES = 1'b0;
	localparam logic CFG_SEARCH_END    = 1'b1;

	typedef enum logic [1:0] {
		ST_OK       = 2'd0,
		ST_NO_SPACE = 2'd1,
		ST_BAD      = 2'd2,
		ST_LONG     = 2'd3
	} status_t;

	typedef struct packed {
		status_t              status;
		logic [CLUS_W-1:0]    first_cluster;
		logic [COUNT_W-1:0]   cluster_count;
		logic [CLUS_W-1:0]    link_value;
	} result_t;

endpackage

[src/fccm_cmd_if.sv]
// Command channel of the cluster chain manager: valid/ready plus command fields.
// Depends on fccm_pkg for the field widths.
interface fccm_cmd_if import fccm_pkg::*; ();
	logic              valid;
	logic              ready;
	logic [FUNC_W-1:0] func;
	logic [SIZE_W-1:0] byte_size;
	logic [CLUS_W-1:0] cluster;
	logic [CLUS_W-1:0] new_link;

	modport source (output valid, func, byte_size, cluster, new_link, input ready);
	modport sink   (input valid, func, byte_size, cluster, new_link, output ready);
endinterface

[src/fccm_res_if.sv]
// Result channel of the cluster chain manager: valid/ready plus result fields.
// Depends on fccm_pkg for the field widths.
interface fccm_res_if import fccm_pkg::*; ();
	logic               valid;
	logic               ready;
	logic [1:0]         status;
	logic [CLUS_W-1:0]  first_cluster;
	logic [COUNT_W-1:0] cluster_count;
	logic [CLUS_W-1:0]  link_value;

	modport source (output valid, status, first_cluster, cluster_count, link_value,
		input ready);
	modport sink   (input valid, status, first_cluster, cluster_count, link_value,
		output ready);
endinterface

[src/fccm_ram.sv]
// Generic single-write, single-read synchronous RAM with a registered read port.
// No dependencies.
module fccm_ram #(
	parameter int WIDTH = 16,
	parameter int DEPTH = 1024
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

[src/fat16_cluster_chain_manager_unit.sv]
// Cluster chain manager: link table in one RAM, sequencer for the five commands.
// Depends on fccm_pkg, fccm_cmd_if, fccm_res_if and fccm_ram.
//
// Usage: commands arrive on cmd (valid/ready), one result per command leaves on
// res (valid/ready). A transfer happens at a rising edge with valid and ready high.
// cmd.ready is high whenever the sequencer is idle, also while the previous result
// still waits in the output register; a finished result waits there until res.ready.
// Configuration is written through cfg_we/cfg_index/cfg_data while idle.
// After reset a clearing pass writes every table entry to free, one per cycle;
// cmd.ready stays low until the pass has written the last entry.
// Allocate and extend scan entries 2 up to min(search_end, TABLE_ENTRIES) - 1.
// Allocate runs a counting scan, then a linking scan, one entry a cycle.
// Free makes two pointer walks, with the read latency on every hop.
// Extend scans for the first free entry from cluster 2.
// The single RAM port pair sets the pace; one command is worked at a time.
module fat16_cluster_chain_manager_unit import fccm_pkg::*; #(
	parameter int TABLE_ENTRIES = 1024
) (
	input  logic              clk,
	input  logic              arst_n,
	fccm_cmd_if.sink          cmd,
	fccm_res_if.source        res,
	input  logic              cfg_we,
	input  logic              cfg_index,
	input  logic [CB_W-1:0]   cfg_data
);

	localparam int AW = $clog2(TABLE_ENTRIES);
	localparam logic [16:0] TE17   = 17'(TABLE_ENTRIES);
	localparam logic [AW:0] LAST   = (AW+1)'(TABLE_ENTRIES - 1);
	localparam logic [AW:0] MAXLEN = (AW+1)'(TABLE_ENTRIES - 2);
	localparam logic [AW:0] SCAN_START = (AW+1)'(2);

	typedef enum logic [4:0] {
		S_CLEAR, S_IDLE,
		S_ALC_CNT, S_ALC_LNK, S_ALC_END,
		S_FRE_RD, S_FRE_CHK, S_FRE_RD2, S_FRE_CLR,
		S_EXT_RD, S_EXT_CHK, S_EXT_SCAN, S_EXT_W2,
		S_RD, S_RD_WAIT, S_WR, S_FIN
	} state_t;

	state_t            state_q;
	logic [CB_W-1:0]   cb_q;
	logic [SE_W-1:0]   se_q;
	logic [SIZE_W-1:0] size_q;
	logic [CLUS_W-1:0] cl_q;
	logic [CLUS_W-1:0] nl_q;
	logic [AW:0]       scan_q;
	logic              vs1_q;
	logic [AW-1:0]     addr_s1;
	logic [32:0]       acc_q;
	logic [AW:0]       taken_q;
	logic [AW-1:0]     prev_q;
	logic [AW-1:0]     first_q;
	logic [AW-1:0]     seed_q;
	result_t           res_q;
	result_t           out_q;
	logic              out_valid_q;

	logic              ram_we;
	logic [AW-1:0]     ram_waddr;
	logic [CLUS_W-1:0] ram_wdata;
	logic              ram_re;
	logic [AW-1:0]     ram_raddr;
	logic [CLUS_W-1:0] ram_rdata;

	logic [CB_W-1:0]   cb_eff;
	logic [16:0]       se17;
	logic [16:0]       lim17;
	logic [AW:0]       lim;
	logic              scan_issue;
	logic              scan_re;
	logic              hit;
	logic [32:0]       acc_nxt;
	logic [AW:0]       cnt_nxt;
	logic              next_is_data;

	function automatic logic is_data(input logic [CLUS_W-1:0] v);
		return (v >= FIRST_DATA) && ({1'b0, v} < TE17);
	endfunction

	function automatic logic in_table(input logic [CLUS_W-1:0] v);
		return {1'b0, v} < TE17;
	endfunction

	function automatic logic [COUNT_W-1:0] to_count(input logic [AW:0] n);
		logic [16:0] w;
		w = 17'(n);
		return w[COUNT_W-1:0];
	endfunction

	fccm_ram #(
		.WIDTH (CLUS_W),
		.DEPTH (TABLE_ENTRIES)
	) u_table (
		.clk   (clk),
		.we    (ram_we),
		.waddr (ram_waddr),
		.wdata (ram_wdata),
		.re    (ram_re),
		.raddr (ram_raddr),
		.rdata (ram_rdata)
	);

	assign cb_eff = (cb_q == '0) ? CB_W'(1) : cb_q;
	assign se17   = 17'(se_q);
	assign lim17  = (se17 > TE17) ? TE17 : se17;
	assign lim    = lim17[AW:0];

	assign hit          = vs1_q && (ram_rdata == FREE_MARK);
	assign acc_nxt      = acc_q + 33'(cb_eff);
	assign cnt_nxt      = taken_q + 1'b1;
	assign next_is_data = is_data(ram_rdata);

	always_comb begin
		scan_issue = 1'b0;
		case (state_q)
			S_ALC_CNT, S_ALC_LNK, S_EXT_SCAN: scan_issue = scan_q < lim;
			default: scan_issue = 1'b0;
		endcase
		// stop reading ahead once extend has its free entry
		scan_re = scan_issue && !((state_q == S_EXT_SCAN) && hit);
	end

	always_comb begin
		ram_we    = 1'b0;
		ram_waddr = '0;
		ram_wdata = '0;
		ram_re    = 1'b0;
		ram_raddr = scan_q[AW-1:0];
		case (state_q)
			S_CLEAR: begin
				ram_we    = 1'b1;
				ram_waddr = scan_q[AW-1:0];
				ram_wdata = FREE_MARK;
			end
			S_ALC_CNT: begin
				ram_re = scan_re;
			end
			S_ALC_LNK: begin
				ram_re = scan_re;
				// link the previous cluster to the one just found
				if (hit && taken_q != '0) begin
					ram_we    = 1'b1;
					ram_waddr = prev_q;
					ram_wdata = CLUS_W'(addr_s1);
				end
			end
			S_ALC_END: begin
				ram_we    = 1'b1;
				ram_waddr = prev_q;
				ram_wdata = END_MARK;
			end
			S_FRE_RD, S_FRE_RD2, S_EXT_RD, S_RD: begin
				ram_re    = 1'b1;
				ram_raddr = seed_q;
			end
			S_FRE_CLR: begin
				ram_we    = 1'b1;
				ram_waddr = seed_q;
				ram_wdata = FREE_MARK;
			end
			S_EXT_SCAN: begin
				ram_re = scan_re;
				if (hit) begin
					ram_we    = 1'b1;
					ram_waddr = seed_q;
					ram_wdata = CLUS_W'(addr_s1);
				end
			end
			S_EXT_W2: begin
				ram_we    = 1'b1;
				ram_waddr = first_q;
				ram_wdata = END_MARK;
			end
			S_WR: begin
				ram_we    = in_table(cl_q);
				ram_waddr = cl_q[AW-1:0];
				ram_wdata = nl_q;
			end
			default: begin
				ram_we = 1'b0;
			end
		endcase
	end

	assign cmd.ready         = (state_q == S_IDLE);
	assign res.valid         = out_valid_q;
	assign res.status        = out_q.status;
	assign res.first_cluster = out_q.first_cluster;
	assign res.cluster_count = out_q.cluster_count;
	assign res.link_value    = out_q.link_value;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_CLEAR;
			cb_q        <= CB_RESET;
			se_q        <= SE_RESET;
			scan_q      <= '0;
			vs1_q       <= 1'b0;
			taken_q     <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (cfg_we) begin
				case (cfg_index)
					CFG_CLUSTER_BYTES: cb_q <= cfg_data;
					CFG_SEARCH_END:    se_q <= cfg_data[SE_W-1:0];
					default:           cb_q <= cb_q;
				endcase
			end

			if (res.valid && res.ready) begin
				out_valid_q <= 1'b0;
			end

			vs1_q   <= scan_re;
			addr_s1 <= scan_q[AW-1:0];

			case (state_q)
				S_CLEAR: begin
					scan_q <= scan_q + 1'b1;
					if (scan_q == LAST) begin
						state_q <= S_IDLE;
					end
				end
				S_IDLE: begin
					if (cmd.valid) begin
						size_q  <= cmd.byte_size;
						cl_q    <= cmd.cluster;
						nl_q    <= cmd.new_link;
						res_q   <= '0;
						seed_q  <= cmd.cluster[AW-1:0];
						taken_q <= '0;
						case (cmd.func)
							FN_ALLOC: begin
								scan_q  <= SCAN_START;
								acc_q   <= '0;
								state_q <= S_ALC_CNT;
							end
							FN_FREE: begin
								if (is_data(cmd.cluster)) begin
									state_q <= S_FRE_RD;
								end else begin
									res_q.status <= ST_BAD;
									state_q      <= S_FIN;
								end
							end
							FN_EXTEND: begin
								if (is_data(cmd.cluster)) begin
									state_q <= S_EXT_RD;
								end else begin
									res_q.status <= ST_BAD;
									state_q      <= S_FIN;
								end
							end
							FN_READ: begin
								if (in_table(cmd.cluster)) begin
									state_q <= S_RD;
								end else begin
									res_q.status <= ST_BAD;
									state_q      <= S_FIN;
								end
							end
							FN_WRITE: begin
								state_q <= S_WR;
							end
							default: begin
								state_q <= S_FIN;
							end
						endcase
					end
				end
				S_ALC_CNT: begin
					if (scan_issue) begin
						scan_q <= scan_q + 1'b1;
					end
					if (hit) begin
						acc_q <= acc_nxt;
					end
					// enough free bytes means enough free clusters
					if (!scan_issue && !vs1_q) begin
						if (acc_q != '0 && acc_q >= {1'b0, size_q}) begin
							scan_q  <= SCAN_START;
							acc_q   <= '0;
							taken_q <= '0;
							state_q <= S_ALC_LNK;
						end else begin
							res_q.status <= ST_NO_SPACE;
							state_q      <= S_FIN;
						end
					end
				end
				S_ALC_LNK: begin
					if (scan_issue) begin
						scan_q <= scan_q + 1'b1;
					end
					if (hit) begin
						if (taken_q == '0) begin
							first_q <= addr_s1;
						end
						prev_q  <= addr_s1;
						taken_q <= cnt_nxt;
						acc_q   <= acc_nxt;
						if (acc_nxt >= {1'b0, size_q}) begin
							vs1_q   <= 1'b0;
							state_q <= S_ALC_END;
						end
					end
				end
				S_ALC_END: begin
					res_q.status        <= ST_OK;
					res_q.first_cluster <= CLUS_W'(first_q);
					res_q.cluster_count <= to_count(taken_q);
					state_q             <= S_FIN;
				end
				S_FRE_RD: begin
					state_q <= S_FRE_CHK;
				end
				S_FRE_CHK: begin
					if (ram_rdata == FREE_MARK) begin
						res_q.status <= ST_BAD;
						state_q      <= S_FIN;
					end else if (cnt_nxt > MAXLEN) begin
						res_q.status <= ST_LONG;
						state_q      <= S_FIN;
					end else if (ram_rdata == END_MARK) begin
						taken_q <= cnt_nxt;
						seed_q  <= cl_q[AW-1:0];
						state_q <= S_FRE_RD2;
					end else if (!next_is_data) begin
						res_q.status <= ST_BAD;
						state_q      <= S_FIN;
					end else begin
						taken_q <= cnt_nxt;
						seed_q  <= ram_rdata[AW-1:0];
						state_q <= S_FRE_RD;
					end
				end
				S_FRE_RD2: begin
					state_q <= S_FRE_CLR;
				end
				S_FRE_CLR: begin
					if (ram_rdata == END_MARK) begin
						res_q.status        <= ST_OK;
						res_q.cluster_count <= to_count(taken_q);
						state_q             <= S_FIN;
					end else begin
						seed_q  <= ram_rdata[AW-1:0];
						state_q <= S_FRE_RD2;
					end
				end
				S_EXT_RD: begin
					state_q <= S_EXT_CHK;
				end
				S_EXT_CHK: begin
					if (ram_rdata != END_MARK) begin
						res_q.status <= ST_BAD;
						state_q      <= S_FIN;
					end else begin
						scan_q  <= SCAN_START;
						state_q <= S_EXT_SCAN;
					end
				end
				S_EXT_SCAN: begin
					if (scan_re) begin
						scan_q <= scan_q + 1'b1;
					end
					if (hit) begin
						first_q <= addr_s1;
						state_q <= S_EXT_W2;
					end else if (!scan_issue && !vs1_q) begin
						res_q.status <= ST_NO_SPACE;
						state_q      <= S_FIN;
					end
				end
				S_EXT_W2: begin
					res_q.status        <= ST_OK;
					res_q.first_cluster <= CLUS_W'(first_q);
					res_q.cluster_count <= COUNT_W'(1);
					state_q             <= S_FIN;
				end
				S_RD: begin
					state_q <= S_RD_WAIT;
				end
				S_RD_WAIT: begin
					res_q.link_value <= ram_rdata;
					state_q          <= S_FIN;
				end
				S_WR: begin
					if (!in_table(cl_q)) begin
						res_q.status <= ST_BAD;
					end
					state_q <= S_FIN;
				end
				S_FIN: begin
					// hold until the output register is free
					if (!out_valid_q || res.ready) begin
						out_q       <= res_q;
						out_valid_q <= 1'b1;
						state_q     <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	a_no_rw_collision: assert property (@(posedge clk) disable iff (!arst_n)
		ram_we && ram_re |-> ram_waddr != ram_raddr)
		else $error("table write and read hit the same entry in one cycle");

	a_result_from_fin: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid_q) |-> $past(state_q == S_FIN))
		else $error("result loaded outside the finish step");

	a_alloc_nonempty: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == S_ALC_END |-> taken_q != '0)
		else $error("allocation closed with no cluster taken");

	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		taken_q <= MAXLEN)
		else $error("cluster count beyond the data area");

endmodule

[test/fat16_cluster_chain_manager_unit_test.sv]
`timescale 1ns / 100ps
// Self-checking bench for the cluster chain manager: directed corner cases, then random
// command phases under several register settings and handshake idle patterns.
// Depends on fccm_pkg, fccm_cmd_if, fccm_res_if and fat16_cluster_chain_manager_unit.
module fat16_cluster_chain_manager_unit_test import fccm_pkg::*;;

	localparam int TABLE_ENTRIES = 1024;
	localparam int CHAIN_MAX     = TABLE_ENTRIES - 2;
	localparam int CYCLE_LIMIT   = 2000000;
	localparam int SETTLE_CYCLES = 40;

	// codes the block ignores
	localparam logic [FUNC_W-1:0] FN_UNUSED_LO = 3'd5;
	localparam logic [FUNC_W-1:0] FN_UNUSED_HI = 3'd7;

	typedef struct packed {
		logic [FUNC_W-1:0] func;
		logic [SIZE_W-1:0] byte_size;
		logic [CLUS_W-1:0] cluster;
		logic [CLUS_W-1:0] new_link;
	} chain_cmd_t;

	logic            clk;
	logic            arst_n;
	logic            cfg_we;
	logic            cfg_index;
	logic [CB_W-1:0] cfg_data;

	fccm_cmd_if cmd_ch();
	fccm_res_if res_ch();

	fat16_cluster_chain_manager_unit #(
		.TABLE_ENTRIES(TABLE_ENTRIES)
	) dut (
		.clk(clk),
		.arst_n(arst_n),
		.cmd(cmd_ch),
		.res(res_ch),
		.cfg_we(cfg_we),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data)
	);

	// shadow of the link table and registers
	logic [CLUS_W-1:0] link_words [TABLE_ENTRIES];
	logic [CB_W-1:0]   bytes_per_cluster;
	logic [SE_W-1:0]   scan_end;

	chain_cmd_t        pending_cmds[$];
	result_t           expected_results[$];
	logic [CLUS_W-1:0] chain_heads[$];

	chain_cmd_t  next_cmd;
	chain_cmd_t  seen_cmd;
	result_t     due_result;
	bit          cmd_fired = 1'b0;
	int unsigned issued_count = 0;
	int unsigned accepted_count = 0;
	int unsigned mismatch_count = 0;
	int unsigned cycle_count = 0;
	int unsigned send_idle_pct = 0;
	int unsigned recv_stall_pct = 0;

	always #2 clk = ~clk;

	always @(posedge clk)
		cycle_count <= cycle_count + 1;

	function automatic int unsigned scan_limit();
		return (scan_end > TABLE_ENTRIES) ? TABLE_ENTRIES : 32'(scan_end);
	endfunction

	function automatic bit is_data(int unsigned c);
		return c >= FIRST_DATA && c < TABLE_ENTRIES;
	endfunction

	function automatic result_t predict_allocate(logic [SIZE_W-1:0] size);
		result_t         r;
		longint unsigned per;
		longint unsigned need;
		longint unsigned avail;
		int unsigned     lim;
		int unsigned     c;
		int unsigned     prev;
		int unsigned     taken;
		int unsigned     first;
		r = '0;
		per = (bytes_per_cluster == 0) ? 64'd1 : 64'(bytes_per_cluster);
		need = ({32'd0, size} + per - 1) / per;
		if (need == 0)
			need = 1;
		lim = scan_limit();
		avail = 0;
		for (c = FIRST_DATA; c < lim; c++)
			if (link_words[c] == FREE_MARK)
				avail++;
		if (avail < need) begin
			r.status = ST_NO_SPACE;
			return r;
		end
		prev = 0;
		taken = 0;
		first = 0;
		for (c = FIRST_DATA; c < lim && taken < need; c++) begin
			if (link_words[c] != FREE_MARK)
				continue;
			if (taken == 0)
				first = c;
			else
				link_words[prev] = CLUS_W'(c);
			link_words[c] = END_MARK;
			prev = c;
			taken++;
		end
		r.status = ST_OK;
		r.first_cluster = CLUS_W'(first);
		r.cluster_count = COUNT_W'(taken);
		return r;
	endfunction

	function automatic result_t predict_free(logic [CLUS_W-1:0] start);
		result_t           r;
		int unsigned       at;
		int unsigned       cnt;
		logic [CLUS_W-1:0] nxt;
		r = '0;
		if (!is_data(32'(start))) begin
			r.status = ST_BAD;
			return r;
		end
		// walk once to validate, then again to clear
		at = 32'(start);
		cnt = 0;
		while (1) begin
			nxt = link_words[at];
			if (nxt == FREE_MARK) begin
				r.status = ST_BAD;
				return r;
			end
			cnt++;
			if (cnt > CHAIN_MAX) begin
				r.status = ST_LONG;
				return r;
			end
			if (nxt == END_MARK)
				break;
			if (!is_data(32'(nxt))) begin
				r.status = ST_BAD;
				return r;
			end
			at = 32'(nxt);
		end
		at = 32'(start);
		while (1) begin
			nxt = link_words[at];
			link_words[at] = FREE_MARK;
			if (nxt == END_MARK)
				break;
			at = 32'(nxt);
		end
		r.status = ST_OK;
		r.cluster_count = COUNT_W'(cnt);
		return r;
	endfunction

	function automatic result_t predict_extend(logic [CLUS_W-1:0] tail);
		result_t     r;
		int unsigned lim;
		int unsigned c;
		int unsigned found;
		r = '0;
		if (!is_data(32'(tail)) || link_words[tail] != END_MARK) begin
			r.status = ST_BAD;
			return r;
		end
		lim = scan_limit();
		found = 0;
		for (c = FIRST_DATA; c < lim && found == 0; c++)
			if (link_words[c] == FREE_MARK)
				found = c;
		if (found == 0) begin
			r.status = ST_NO_SPACE;
			return r;
		end
		link_words[tail] = CLUS_W'(found);
		link_words[found] = END_MARK;
		r.status = ST_OK;
		r.first_cluster = CLUS_W'(found);
		r.cluster_count = COUNT_W'(1);
		return r;
	endfunction

	function automatic result_t predict_chain_op(chain_cmd_t c);
		result_t r;
		int      i;
		r = '0;
		r.status = ST_OK;
		case (c.func)
			FN_ALLOC: begin
				r = predict_allocate(c.byte_size);
				if (r.status == ST_OK) begin
					chain_heads.push_back(r.first_cluster);
					if (chain_heads.size() > 48)
						void'(chain_heads.pop_front());
				end
			end
			FN_FREE: begin
				r = predict_free(c.cluster);
				if (r.status == ST_OK)
					for (i = chain_heads.size() - 1; i >= 0; i--)
						if (chain_heads[i] == c.cluster)
							chain_heads.delete(i);
			end
			FN_EXTEND: r = predict_extend(c.cluster);
			FN_READ: begin
				if (c.cluster < TABLE_ENTRIES)
					r.link_value = link_words[c.cluster];
				else
					r.status = ST_BAD;
			end
			FN_WRITE: begin
				if (c.cluster < TABLE_ENTRIES)
					link_words[c.cluster] = c.new_link;
				else
					r.status = ST_BAD;
			end
			default: ;
		endcase
		return r;
	endfunction

	// follow a chain to its end mark; fall back to the head on anything odd
	function automatic logic [CLUS_W-1:0] chain_tail(logic [CLUS_W-1:0] head);
		logic [CLUS_W-1:0] at;
		int unsigned       hop;
		at = head;
		for (hop = 0; hop < TABLE_ENTRIES; hop++) begin
			if (!is_data(32'(at)) || link_words[at] == FREE_MARK)
				return head;
			if (link_words[at] == END_MARK)
				return at;
			at = link_words[at];
		end
		return head;
	endfunction

	function automatic chain_cmd_t make_random_cmd();
		chain_cmd_t  c;
		int unsigned pick;
		int unsigned sel;
		int unsigned lim;
		int unsigned per;
		c.func = FN_READ;
		c.byte_size = $urandom;
		c.cluster = CLUS_W'($urandom);
		c.new_link = CLUS_W'($urandom);
		lim = scan_limit();
		per = (bytes_per_cluster == 0) ? 1 : 32'(bytes_per_cluster);
		pick = $urandom_range(99, 0);
		sel = $urandom_range(99, 0);
		if (pick < 30) begin
			c.func = FN_ALLOC;
			if (sel < 70)
				c.byte_size = $urandom_range(per * 4, 0);
			else if (sel < 85)
				c.byte_size = per * $urandom_range(3, 1);
		end else if (pick < 55) begin
			c.func = FN_FREE;
			if (chain_heads.size() != 0 && sel < 80)
				c.cluster = chain_heads[$urandom_range(chain_heads.size() - 1, 0)];
			else if (sel < 92)
				c.cluster = CLUS_W'($urandom_range(lim + 2, 0));
		end else if (pick < 70) begin
			c.func = FN_EXTEND;
			if (chain_heads.size() != 0 && sel < 80)
				c.cluster = chain_tail(chain_heads[$urandom_range(chain_heads.size() - 1, 0)]);
			else if (sel < 92)
				c.cluster = CLUS_W'($urandom_range(lim + 2, 0));
		end else if (pick < 85) begin
			if (sel < 85)
				c.cluster = CLUS_W'($urandom_range(lim + 2, 0));
		end else if (pick < 96) begin
			c.func = FN_WRITE;
			if (sel < 85)
				c.cluster = CLUS_W'($urandom_range(lim, 0));
			sel = $urandom_range(99, 0);
			if (sel < 40)
				c.new_link = FREE_MARK;
			else if (sel < 65)
				c.new_link = END_MARK;
			else if (sel < 90)
				c.new_link = CLUS_W'($urandom_range(lim + 1, FIRST_DATA));
		end else begin
			c.func = FUNC_W'($urandom_range(FN_UNUSED_HI, FN_UNUSED_LO));
		end
		return c;
	endfunction

	task automatic flag_mismatch(string field, logic [31:0] got, logic [31:0] want);
		mismatch_count++;
		$display("%0t ns: %s is %0h, expected %0h", $time, field, got, want);
	endtask

	task automatic queue_cmd(logic [FUNC_W-1:0] func, logic [SIZE_W-1:0] size,
		logic [CLUS_W-1:0] cl, logic [CLUS_W-1:0] nl);
		chain_cmd_t c;
		c.func = func;
		c.byte_size = size;
		c.cluster = cl;
		c.new_link = nl;
		pending_cmds.push_back(c);
		issued_count++;
	endtask

	task automatic write_register(logic idx, logic [CB_W-1:0] value);
		@(negedge clk);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_data <= value;
		@(negedge clk);
		cfg_we <= 1'b0;
	endtask

	task automatic wait_idle();
		while (accepted_count != issued_count || expected_results.size() != 0)
			@(negedge clk);
	endtask

	task automatic run_phase(logic [CB_W-1:0] cb, logic [CB_W-1:0] se_word,
		int unsigned sidle, int unsigned rstall, int unsigned n);
		chain_cmd_t  c;
		int unsigned k;
		send_idle_pct = sidle;
		recv_stall_pct = rstall;
		write_register(CFG_CLUSTER_BYTES, cb);
		write_register(CFG_SEARCH_END, se_word);
		// keep the queue shallow so new commands see a fresh table
		for (k = 0; k < n; k++) begin
			while (pending_cmds.size() >= 2)
				@(negedge clk);
			c = make_random_cmd();
			queue_cmd(c.func, c.byte_size, c.cluster, c.new_link);
		end
		wait_idle();
	endtask

	// driver: hold valid until the transfer, then advance
	always @(negedge clk) begin
		if (arst_n) begin
			if (cmd_fired || !cmd_ch.valid) begin
				cmd_fired = 1'b0;
				if (pending_cmds.size() != 0 && $urandom_range(99, 0) >= send_idle_pct) begin
					next_cmd = pending_cmds.pop_front();
					cmd_ch.valid <= 1'b1;
					cmd_ch.func <= next_cmd.func;
					cmd_ch.byte_size <= next_cmd.byte_size;
					cmd_ch.cluster <= next_cmd.cluster;
					cmd_ch.new_link <= next_cmd.new_link;
				end else begin
					cmd_ch.valid <= 1'b0;
				end
			end
			res_ch.ready <= ($urandom_range(99, 0) >= recv_stall_pct);
		end
	end

	// monitor: register writes, command transfers and result checks
	always @(posedge clk) begin
		if (arst_n) begin
			if (cfg_we) begin
				if (cfg_index == CFG_CLUSTER_BYTES)
					bytes_per_cluster = cfg_data;
				else
					scan_end = cfg_data[SE_W-1:0];
			end
			if (cmd_ch.valid && cmd_ch.ready) begin
				seen_cmd = {cmd_ch.func, cmd_ch.byte_size, cmd_ch.cluster, cmd_ch.new_link};
				expected_results.push_back(predict_chain_op(seen_cmd));
				accepted_count++;
				cmd_fired = 1'b1;
			end
			if (res_ch.valid && res_ch.ready) begin
				if (expected_results.size() == 0) begin
					flag_mismatch("unexpected result, status", 32'(res_ch.status), 0);
				end else begin
					due_result = expected_results.pop_front();
					if (res_ch.status !== due_result.status)
						flag_mismatch("status", 32'(res_ch.status), 32'(due_result.status));
					if (res_ch.first_cluster !== due_result.first_cluster)
						flag_mismatch("first_cluster", 32'(res_ch.first_cluster),
							32'(due_result.first_cluster));
					if (res_ch.cluster_count !== due_result.cluster_count)
						flag_mismatch("cluster_count", 32'(res_ch.cluster_count),
							32'(due_result.cluster_count));
					if (res_ch.link_value !== due_result.link_value)
						flag_mismatch("link_value", 32'(res_ch.link_value),
							32'(due_result.link_value));
				end
			end
		end
	end

	initial begin
		wait (cycle_count >= CYCLE_LIMIT);
		$display("end of test: mismatches");
		$finish;
	end

	initial begin
		int unsigned idx;
		clk = 1'b0;
		arst_n = 1'b0;
		cfg_we = 1'b0;
		cfg_index = CFG_CLUSTER_BYTES;
		cfg_data = '0;
		cmd_ch.valid = 1'b0;
		cmd_ch.func = FN_READ;
		cmd_ch.byte_size = '0;
		cmd_ch.cluster = '0;
		cmd_ch.new_link = '0;
		res_ch.ready = 1'b0;
		bytes_per_cluster = CB_RESET;
		scan_end = SE_RESET;
		for (idx = 0; idx < TABLE_ENTRIES; idx++)
			link_words[idx] = FREE_MARK;
		repeat (3) @(negedge clk);
		arst_n <= 1'b1;

		// corner cases under the reset settings
		queue_cmd(FN_READ, 0, 0, 0);
		queue_cmd(FN_READ, 0, CLUS_W'(TABLE_ENTRIES - 1), 0);
		queue_cmd(FN_READ, 0, 16'hFFFF, 0);
		queue_cmd(FN_WRITE, 0, CLUS_W'(TABLE_ENTRIES), 16'h1234);
		queue_cmd(FN_ALLOC, 0, 0, 0);
		queue_cmd(FN_ALLOC, 2049, 0, 0);
		queue_cmd(FN_ALLOC, 32'hFFFF_FFFF, 0, 0);
		queue_cmd(FN_EXTEND, 0, 4, 0);
		queue_cmd(FN_EXTEND, 0, 3, 0);
		queue_cmd(FN_EXTEND, 0, 16'hFFFF, 0);
		queue_cmd(FN_FREE, 0, 3, 0);
		queue_cmd(FN_FREE, 0, 3, 0);
		queue_cmd(FN_FREE, 0, 1, 0);
		// two entries pointing at each other never reach an end mark
		queue_cmd(FN_WRITE, 0, 10, 11);
		queue_cmd(FN_WRITE, 0, 11, 10);
		queue_cmd(FN_FREE, 0, 10, 0);
		queue_cmd(FN_WRITE, 0, 11, 16'hFF00);
		queue_cmd(FN_FREE, 0, 10, 0);
		queue_cmd(FN_WRITE, 0, 1, 16'h00FF);
		queue_cmd(FN_READ, 0, 1, 0);
		queue_cmd(FN_WRITE, 0, 10, FREE_MARK);
		queue_cmd(FN_WRITE, 0, 11, FREE_MARK);
		queue_cmd(FN_UNUSED_LO, 32'hFFFF_FFFF, 16'hFFFF, 16'hFFFF);
		queue_cmd(FN_UNUSED_HI, 0, 5, 0);
		queue_cmd(FN_FREE, 0, 2, 0);
		wait_idle();

		run_phase(17'd65536, 17'd3, 81, 0, 25);
		run_phase(17'd512, 17'd40, 0, 0, 60);
		run_phase(17'd0, 17'd24, 0, 81, 40);
		// upper bits of the search_end word are dropped by the register
		run_phase(17'h1FFFF, 17'h1FFFF, 14, 14, 30);
		run_phase(17'd4096, 17'd1024, 81, 81, 35);
		run_phase(17'd1000, 17'd64, 0, 0, 50);
		run_phase(CB_RESET, 17'(SE_RESET), 14, 14, 40);

		repeat (SETTLE_CYCLES) @(negedge clk);
		if (mismatch_count == 0 && expected_results.size() == 0)
			$display("end of test: clean");
		else
			$display("end of test: mismatches");
		$finish;
	end

endmodule
